// File: rtl/ray_segment_intersection_defines.svh
// Assertion macros for the ray/segment intersection block.
`ifndef RAY_SEGMENT_INTERSECTION_DEFINES_SVH
`define RAY_SEGMENT_INTERSECTION_DEFINES_SVH

// Antecedent implies consequent on the next clock edge, outside reset.
`define RSI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle, outside reset.
`define RSI_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/rsi_pkg.sv
package rsi_pkg;
    localparam int COORD_WIDTH = 24;
    localparam int DIR_WIDTH   = 16;
    localparam int T_FRAC_BITS = 16;

    // a-b and a-r differences
    localparam int DIFF_WIDTH = COORD_WIDTH + 1;
    // den and tn: difference of two products of DIFF_WIDTH x DIR_WIDTH
    localparam int PROD_WIDTH = DIFF_WIDTH + DIR_WIDTH + 1;
    // magnitude of den / tn
    localparam int MAG_WIDTH  = PROD_WIDTH;
    // un products: DIFF_WIDTH x DIFF_WIDTH
    localparam int UPROD_WIDTH = 2 * DIFF_WIDTH;
    localparam int UN_WIDTH    = UPROD_WIDTH + 1;
    // tq * (b-a)
    localparam int SCALE_WIDTH = T_FRAC_BITS + 1 + DIFF_WIDTH;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIR_WIDTH-1:0]   dir_t;
endpackage

// File: rtl/ray_segment_intersection.sv
// Fully pipelined ray/wall-segment intersection, one transaction per cycle while the
// output is not stalled; a stall freezes every stage.
// Throughput: one transaction per clock unless stalled; the restoring divider is unrolled
// into one register stage per quotient bit, and the output stage is a skid-free register.
// Reset: aresetn synchronous active low clears all stage valid bits; data is not reset.
`include "ray_segment_intersection_defines.svh"

module ray_segment_intersection (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rsi_pkg::coord_t      s_wall_ax,
    input  rsi_pkg::coord_t      s_wall_ay,
    input  rsi_pkg::coord_t      s_wall_bx,
    input  rsi_pkg::coord_t      s_wall_by,
    input  rsi_pkg::coord_t      s_ray_x,
    input  rsi_pkg::coord_t      s_ray_y,
    input  rsi_pkg::dir_t        s_ray_dx,
    input  rsi_pkg::dir_t        s_ray_dy,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_hit,
    output rsi_pkg::coord_t      m_hit_x,
    output rsi_pkg::coord_t      m_hit_y
);
    import rsi_pkg::*;

    // Stages:
    //  S1  differences e = a-b, f = a-r, g = b-a
    //  S2  four direction products, two un products
    //  S3  den, tn, un sums
    //  S4  sign/trivial miss checks, magnitudes, u>0 flag
    //  D0..D(T-1) one restoring divide step per stage
    //  M   tq * g products
    //  O   floor scaling and final add, output register
    localparam int NDIV = T_FRAC_BITS;

    // The whole pipe advances together; a stall freezes every stage.
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // ---------------- S1 ----------------
    logic                         v1_reg;
    logic signed [DIFF_WIDTH-1:0] ex1_reg, ey1_reg, fx1_reg, fy1_reg, gx1_reg, gy1_reg;
    coord_t                       ax1_reg, ay1_reg;
    dir_t                         dx1_reg, dy1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
        end
        if (adv) begin
            ex1_reg <= DIFF_WIDTH'(s_wall_ax) - DIFF_WIDTH'(s_wall_bx);
            ey1_reg <= DIFF_WIDTH'(s_wall_ay) - DIFF_WIDTH'(s_wall_by);
            fx1_reg <= DIFF_WIDTH'(s_wall_ax) - DIFF_WIDTH'(s_ray_x);
            fy1_reg <= DIFF_WIDTH'(s_wall_ay) - DIFF_WIDTH'(s_ray_y);
            gx1_reg <= DIFF_WIDTH'(s_wall_bx) - DIFF_WIDTH'(s_wall_ax);
            gy1_reg <= DIFF_WIDTH'(s_wall_by) - DIFF_WIDTH'(s_wall_ay);
            ax1_reg <= s_wall_ax;
            ay1_reg <= s_wall_ay;
            dx1_reg <= s_ray_dx;
            dy1_reg <= s_ray_dy;
        end
    end

    // ---------------- S2 ----------------
    localparam int DP_WIDTH = DIFF_WIDTH + DIR_WIDTH;
    logic                          v2_reg;
    logic signed [DP_WIDTH-1:0]    eydx2_reg, exdy2_reg, fydx2_reg, fxdy2_reg;
    logic signed [UPROD_WIDTH-1:0] eyfx2_reg, exfy2_reg;
    logic signed [DIFF_WIDTH-1:0]  gx2_reg, gy2_reg;
    coord_t                        ax2_reg, ay2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
        if (adv) begin
            eydx2_reg <= DP_WIDTH'(ey1_reg) * DP_WIDTH'(dx1_reg);
            exdy2_reg <= DP_WIDTH'(ex1_reg) * DP_WIDTH'(dy1_reg);
            fydx2_reg <= DP_WIDTH'(fy1_reg) * DP_WIDTH'(dx1_reg);
            fxdy2_reg <= DP_WIDTH'(fx1_reg) * DP_WIDTH'(dy1_reg);
            eyfx2_reg <= UPROD_WIDTH'(ey1_reg) * UPROD_WIDTH'(fx1_reg);
            exfy2_reg <= UPROD_WIDTH'(ex1_reg) * UPROD_WIDTH'(fy1_reg);
            gx2_reg   <= gx1_reg;
            gy2_reg   <= gy1_reg;
            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;
        end
    end

    // ---------------- S3 ----------------
    logic                         v3_reg;
    logic signed [PROD_WIDTH-1:0] den3_reg, tn3_reg;
    logic signed [UN_WIDTH-1:0]   un3_reg;
    logic signed [DIFF_WIDTH-1:0] gx3_reg, gy3_reg;
    coord_t                       ax3_reg, ay3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
        if (adv) begin
            den3_reg <= PROD_WIDTH'(eydx2_reg) - PROD_WIDTH'(exdy2_reg);
            tn3_reg  <= PROD_WIDTH'(fydx2_reg) - PROD_WIDTH'(fxdy2_reg);
            un3_reg  <= UN_WIDTH'(eyfx2_reg) - UN_WIDTH'(exfy2_reg);
            gx3_reg  <= gx2_reg;
            gy3_reg  <= gy2_reg;
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
        end
    end

    // ---------------- S4 ----------------
    // S4 registers are entry 0 of the divider arrays below.
    logic [MAG_WIDTH-1:0]  dmag4_next, rmag4_next;
    logic                  ok4_next;

    always_comb begin
        dmag4_next = den3_reg[PROD_WIDTH-1] ? MAG_WIDTH'(-den3_reg) : MAG_WIDTH'(den3_reg);
        rmag4_next = tn3_reg[PROD_WIDTH-1]  ? MAG_WIDTH'(-tn3_reg)  : MAG_WIDTH'(tn3_reg);
        // u > 0 when un has the nonzero sign of den; t in (0,1) requires same signs.
        ok4_next = (den3_reg != '0) && (tn3_reg != '0)
                && (tn3_reg[PROD_WIDTH-1] == den3_reg[PROD_WIDTH-1])
                && (un3_reg != '0)
                && (un3_reg[UN_WIDTH-1] == den3_reg[PROD_WIDTH-1]);
    end

    // ---------------- divider stages ----------------
    // When ok holds the remainder stays below d, so one extra bit holds the doubled value.
    logic [NDIV:0]                v_d_reg;
    logic [NDIV:0]                ok_d_reg;
    logic [MAG_WIDTH-1:0]         d_d_reg [NDIV+1];
    logic [MAG_WIDTH-1:0]         r_d_reg [NDIV+1];
    logic [T_FRAC_BITS-1:0]       q_d_reg [NDIV+1];
    logic signed [DIFF_WIDTH-1:0] gx_d_reg [NDIV+1];
    logic signed [DIFF_WIDTH-1:0] gy_d_reg [NDIV+1];
    coord_t                       ax_d_reg [NDIV+1];
    coord_t                       ay_d_reg [NDIV+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_d_reg[0] <= 1'b0;
        end else if (adv) begin
            v_d_reg[0] <= v3_reg;
        end
        if (adv) begin
            ok_d_reg[0] <= ok4_next && (rmag4_next < dmag4_next);
            d_d_reg[0]  <= dmag4_next;
            r_d_reg[0]  <= rmag4_next;
            q_d_reg[0]  <= '0;
            gx_d_reg[0] <= gx3_reg;
            gy_d_reg[0] <= gy3_reg;
            ax_d_reg[0] <= ax3_reg;
            ay_d_reg[0] <= ay3_reg;
        end
    end

    for (genvar i = 0; i < NDIV; i++) begin : g_div
        logic [MAG_WIDTH:0]   r2;
        logic                 ge;
        assign r2 = {r_d_reg[i], 1'b0};
        assign ge = r2 >= {1'b0, d_d_reg[i]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_d_reg[i+1] <= 1'b0;
            end else if (adv) begin
                v_d_reg[i+1] <= v_d_reg[i];
            end
            if (adv) begin
                ok_d_reg[i+1] <= ok_d_reg[i];
                d_d_reg[i+1]  <= d_d_reg[i];
                r_d_reg[i+1]  <= ge ? MAG_WIDTH'(r2 - {1'b0, d_d_reg[i]})
                                    : MAG_WIDTH'(r2);
                q_d_reg[i+1]  <= {q_d_reg[i][T_FRAC_BITS-2:0], ge};
                gx_d_reg[i+1] <= gx_d_reg[i];
                gy_d_reg[i+1] <= gy_d_reg[i];
                ax_d_reg[i+1] <= ax_d_reg[i];
                ay_d_reg[i+1] <= ay_d_reg[i];
            end
        end
    end

    // ---------------- multiply stage ----------------
    logic                          vm_reg, okm_reg;
    logic signed [SCALE_WIDTH-1:0] px_m_reg, py_m_reg;
    coord_t                        axm_reg, aym_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm_reg <= 1'b0;
        end else if (adv) begin
            vm_reg <= v_d_reg[NDIV];
        end
        if (adv) begin
            okm_reg  <= ok_d_reg[NDIV] && (q_d_reg[NDIV] != '0);
            px_m_reg <= SCALE_WIDTH'($signed({1'b0, q_d_reg[NDIV]}))
                      * SCALE_WIDTH'(gx_d_reg[NDIV]);
            py_m_reg <= SCALE_WIDTH'($signed({1'b0, q_d_reg[NDIV]}))
                      * SCALE_WIDTH'(gy_d_reg[NDIV]);
            axm_reg  <= ax_d_reg[NDIV];
            aym_reg  <= ay_d_reg[NDIV];
        end
    end

    // ---------------- output stage ----------------
    // Arithmetic shift right is floor division by 2^T_FRAC_BITS.
    logic                          m_valid_reg, m_hit_reg;
    coord_t                        m_hit_x_reg, m_hit_y_reg;
    logic signed [SCALE_WIDTH-1:0] sx, sy;

    assign sx = px_m_reg >>> T_FRAC_BITS;
    assign sy = py_m_reg >>> T_FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vm_reg;
        end
        if (adv) begin
            m_hit_reg   <= okm_reg;
            m_hit_x_reg <= okm_reg ? COORD_WIDTH'(axm_reg + COORD_WIDTH'(sx)) : '0;
            m_hit_y_reg <= okm_reg ? COORD_WIDTH'(aym_reg + COORD_WIDTH'(sy)) : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_hit   = m_hit_reg;
    assign m_hit_x = m_hit_x_reg;
    assign m_hit_y = m_hit_y_reg;

    // ---------------- assertions ----------------
    `RSI_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_hit) && $stable(m_hit_x), "result changed during stall")
    `RSI_ASSERT_NOW(a_miss_zero, aclk, aresetn, m_valid && !m_hit,
        m_hit_x == '0 && m_hit_y == '0, "miss carries nonzero point")
    `RSI_ASSERT_NOW(a_ready_link, aclk, aresetn, 1'b1,
        s_ready == (!m_valid || m_ready), "input ready not tied to output drain")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

// Scoreboard: predicts the intersection for each accepted transaction and
// checks results in order.
class hit_scoreboard;
    typedef struct {
        logic                hit;
        rsi_pkg::coord_t     hx;
        rsi_pkg::coord_t     hy;
    } hit_point_t;

    hit_point_t pending[$];
    int         errors;

    // floor(p / 2^T_FRAC_BITS)
    static function longint scale_down(longint p);
        longint rnd;
        rnd = (64'sd1 <<< rsi_pkg::T_FRAC_BITS) - 1;
        if (p >= 0)
            return p >>> rsi_pkg::T_FRAC_BITS;
        return -((-p + rnd) >>> rsi_pkg::T_FRAC_BITS);
    endfunction

    function void note_segment(rsi_pkg::coord_t ax, rsi_pkg::coord_t ay,
                               rsi_pkg::coord_t bx, rsi_pkg::coord_t by,
                               rsi_pkg::coord_t rx, rsi_pkg::coord_t ry,
                               rsi_pkg::dir_t dx, rsi_pkg::dir_t dy);
        longint     ex, ey, fx, fy, den, tn, d, r, tq;
        logic signed [127:0] p, q;
        logic       upos;
        hit_point_t e;
        e = '{1'b0, '0, '0};
        ex = longint'(ax) - longint'(bx);
        ey = longint'(ay) - longint'(by);
        fx = longint'(ax) - longint'(rx);
        fy = longint'(ay) - longint'(ry);
        den = ey * longint'(dx) - ex * longint'(dy);
        tn = fy * longint'(dx) - fx * longint'(dy);
        if (den != 0 && tn != 0 && ((tn < 0) == (den < 0))) begin
            d = den < 0 ? -den : den;
            r = tn < 0 ? -tn : tn;
            if (r < d) begin
                // restoring division, truncated t
                tq = 0;
                for (int i = 0; i < rsi_pkg::T_FRAC_BITS; i++) begin
                    r = r <<< 1;
                    tq = tq <<< 1;
                    if (r >= d) begin
                        r = r - d;
                        tq = tq | 1;
                    end
                end
                p = 128'(signed'(ey)) * 128'(signed'(fx));
                q = 128'(signed'(ex)) * 128'(signed'(fy));
                upos = (den > 0) ? (p > q) : (q > p);
                if (tq != 0 && upos) begin
                    e.hit = 1'b1;
                    e.hx = rsi_pkg::coord_t'(longint'(ax)
                           + scale_down(tq * (longint'(bx) - longint'(ax))));
                    e.hy = rsi_pkg::coord_t'(longint'(ay)
                           + scale_down(tq * (longint'(by) - longint'(ay))));
                end
            end
        end
        pending.push_back(e);
    endfunction

    function void check_point(logic hit, rsi_pkg::coord_t hx, rsi_pkg::coord_t hy);
        hit_point_t e;
        if (pending.size() == 0) begin
            $error("unexpected result hit=%0d x=%0d y=%0d", hit, hx, hy);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (hit !== e.hit) begin
            $error("hit: expected %0d actual %0d", e.hit, hit);
            errors++;
        end
        if (hx !== e.hx) begin
            $error("hit_x: expected %0d actual %0d", e.hx, hx);
            errors++;
        end
        if (hy !== e.hy) begin
            $error("hit_y: expected %0d actual %0d", e.hy, hy);
            errors++;
        end
    endfunction
endclass

module testbench;
    import rsi_pkg::*;

    localparam int LATENCY     = T_FRAC_BITS + 6;
    localparam int CYCLE_LIMIT = 400000;

    logic   aclk = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    coord_t s_wall_ax = '0, s_wall_ay = '0, s_wall_bx = '0, s_wall_by = '0;
    coord_t s_ray_x = '0, s_ray_y = '0;
    dir_t   s_ray_dx = '0, s_ray_dy = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    logic   m_hit;
    coord_t m_hit_x, m_hit_y;

    hit_scoreboard sb = new();
    int     send_idle_pct = 0;   // sender idle percentage for the current phase
    int     recv_stall_pct = 0;  // receiver stall percentage
    longint cycles = 0;

    always #5 aclk = ~aclk;

    ray_segment_intersection u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_wall_ax (s_wall_ax),
        .s_wall_ay (s_wall_ay),
        .s_wall_bx (s_wall_bx),
        .s_wall_by (s_wall_by),
        .s_ray_x   (s_ray_x),
        .s_ray_y   (s_ray_y),
        .s_ray_dx  (s_ray_dx),
        .s_ray_dy  (s_ray_dy),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_hit     (m_hit),
        .m_hit_x   (m_hit_x),
        .m_hit_y   (m_hit_y)
    );

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: random stalls, check every accepted transaction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_point(m_hit, m_hit_x, m_hit_y);
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Drive one transaction: optional idle gap, then hold valid until accepted.
    task automatic send_segment(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                coord_t rx, coord_t ry, dir_t dx, dir_t dy);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_wall_ax <= ax;
        s_wall_ay <= ay;
        s_wall_bx <= bx;
        s_wall_by <= by;
        s_ray_x   <= rx;
        s_ray_y   <= ry;
        s_ray_dx  <= dx;
        s_ray_dy  <= dy;
        do @(posedge aclk); while (!s_ready);
        sb.note_segment(ax, ay, bx, by, rx, ry, dx, dy);
    endtask

    function automatic coord_t rand_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($signed($urandom_range(8191)) - 4096);
            default: return coord_t'($signed($urandom_range(512000)) - 256000);
        endcase
    endfunction

    function automatic dir_t rand_dir(int mode);
        if (mode == 0)
            return dir_t'($urandom);
        return dir_t'($signed($urandom_range(32768)) - 16384);
    endfunction

    // Mostly rays aimed at a point on the wall, so hits are common.
    task automatic send_random();
        coord_t ax, ay, bx, by, rx, ry;
        dir_t   dx, dy;
        int     mode;
        longint tx, ty, vx, vy, sc;
        mode = $urandom_range(2);
        ax = rand_coord(mode);
        ay = rand_coord(mode);
        bx = rand_coord(mode);
        by = rand_coord(mode);
        rx = rand_coord(mode);
        ry = rand_coord(mode);
        if ($urandom_range(3) != 0) begin
            // aim at a random point on the wall, scale into direction range
            tx = longint'(ax)
               + ((longint'(bx) - longint'(ax)) * longint'($urandom_range(256))) / 256;
            ty = longint'(ay)
               + ((longint'(by) - longint'(ay)) * longint'($urandom_range(256))) / 256;
            vx = tx - longint'(rx);
            vy = ty - longint'(ry);
            sc = 1;
            while ((vx / sc) > 16384 || (vx / sc) < -16384 ||
                   (vy / sc) > 16384 || (vy / sc) < -16384)
                sc = sc * 2;
            dx = dir_t'(vx / sc);
            dy = dir_t'(vy / sc);
        end else begin
            dx = rand_dir($urandom_range(1));
            dy = rand_dir($urandom_range(1));
        end
        send_segment(ax, ay, bx, by, rx, ry, dx, dy);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: plain hit, parallel, zero direction, behind ray,
        // endpoints, tiny t, extremes, out-of-range directions.
        send_segment(-24'sd2560, 24'sd2560, 24'sd2560, 24'sd2560, 0, 0, 0, 16'sd16384);
        send_segment(-24'sd2560, 24'sd2560, 24'sd2560, 24'sd2560, 0, 0, 16'sd16384, 0);
        send_segment(-24'sd2560, 24'sd2560, 24'sd2560, 24'sd2560, 0, 0, 0, 0);
        send_segment(-24'sd2560, 24'sd2560, 24'sd2560, 24'sd2560, 0, 0, 0, -16'sd16384);
        send_segment(0, 24'sd2560, 24'sd2560, 24'sd2560, 0, 0, 0, 16'sd16384);
        send_segment(-24'sd2560, 24'sd2560, 0, 24'sd2560, 0, 0, 0, 16'sd16384);
        send_segment(24'sd1, 24'sd256, -24'sd8388608, 24'sd256, 0, 0, 0, 16'sd16384);
        send_segment(-24'sd8388608, -24'sd8388608, 24'sd8388607, 24'sd8388607,
                     24'sd8388607, -24'sd8388608, -16'sd16384, 16'sd16384);
        send_segment(24'sd8388607, -24'sd8388608, -24'sd8388608, 24'sd8388607,
                     -24'sd8388608, -24'sd8388608, 16'sd32767, 16'sd32767);
        send_segment(-24'sd8388608, 24'sd8388607, 24'sd8388607, -24'sd8388608,
                     24'sd8388607, 24'sd8388607, -16'sd32768, -16'sd32768);
        send_segment(24'sd100, 24'sd100, 24'sd100, 24'sd100, 0, 0, 16'sd100, 16'sd100);
        send_segment('1, '1, '1, '1, '1, '1, '1, '1);
        send_segment('0, '0, '0, '0, '0, '0, '0, '0);
        send_segment(-24'sd1000, 24'sd50, 24'sd1000, -24'sd50, 24'sd3, -24'sd7,
                     16'sd11585, -16'sd11585);

        // Random phases: none, sender idle, receiver stall, both.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 77 : (ph == 3) ? 28 : 0;
            recv_stall_pct = (ph == 2) ? 77 : (ph == 3) ? 28 : 0;
            for (int i = 0; i < 300; i++)
                send_random();
        end
        s_valid <= 1'b0;
        recv_stall_pct = 0;

        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);

        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
